/* rtl/mwo_pkg.sv */
// shared types and constants for the multi-waveform oscillator
package mwo_pkg;

  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 3;
  localparam int INC_W       = 32;
  localparam int FRAC_W      = 32;
  localparam int SKEW_W      = 16;
  localparam int CONST_W     = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_PHASE_INCREMENT = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WAVEFORM        = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SKEW            = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_CONSTANT_VALUE  = 3'd3;

  localparam longint unsigned Q30_ONE     = 64'd1 << 30;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [1:0] {
    WAVE_SINE     = 2'd0,
    WAVE_SQUARE   = 2'd1,
    WAVE_TRIANGLE = 2'd2,
    WAVE_CONST    = 2'd3
  } wave_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_EVAL,
    ST_SINE_RD,
    ST_SINE_OUT,
    ST_DIVIDE,
    ST_DIV_OUT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic idx_en;
    logic rd_en;
  } sine_ctl_t;

endpackage

/* rtl/mwo_in_if.sv */
// input item channel: restart flag with valid/ready
interface mwo_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

/* rtl/mwo_out_if.sv */
// result item channel: signed sample with valid/ready
interface mwo_out_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

/* rtl/multi_waveform_oscillator_core.sv */
// top level: config registers, sequencer and output register of the oscillator
//
//   channel   dir   handshake     payload
//   tick      in    valid/ready   restart
//   wave      out   valid/ready   sample (SAMPLE_BITS, signed)
//   cfg       in    cfg_write     cfg_index, cfg_data
//
// one item at a time; the phase add runs one bit a cycle
// states per item: constant goes straight to finish; square runs accum, eval, finish; sine adds sine_rd, sine_out;
// triangle adds divide, div_out (divider gives SAMPLE_BITS+1 quotient bits, one a cycle)
// a new item is taken while the previous sample waits in the output register
// synchronous reset clears phase and control state and sets the config registers to defaults (skew 0x8000)
module multi_waveform_oscillator_core #(
  parameter int PHASE_BITS       = 32,
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int SAMPLE_BITS      = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [mwo_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [mwo_pkg::CFG_DATA_W-1:0]     cfg_data,
  mwo_in_if.sink                             tick,
  mwo_out_if.source                          wave
);
  import mwo_pkg::*;

  localparam logic signed [SAMPLE_BITS-1:0] FULL_POS = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] FULL_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [FRAC_W:0]               ONE_CYCLE = {1'b1, {FRAC_W{1'b0}}};

  logic [INC_W-1:0]                 phase_increment;
  wave_t                            waveform;
  logic [SKEW_W-1:0]                skew;
  logic signed [CONST_W-1:0]        constant_value;

  state_t                           state;
  state_t                           state_next;
  logic                             accept;
  logic                             out_free;
  logic                             out_load;

  logic                             acc_start;
  logic                             acc_clear;
  logic                             acc_done;
  logic [FRAC_W-1:0]                frac;

  sine_ctl_t                        sine_ctl;
  logic signed [SAMPLE_BITS-1:0]    sine_value;

  logic                             div_start;
  logic                             div_done;
  logic [FRAC_W:0]                  div_num;
  logic [FRAC_W:0]                  div_den;
  logic [SAMPLE_BITS:0]             quot;

  logic [FRAC_W:0]                  skew_point;
  logic                             rising;
  logic signed [SAMPLE_BITS+CONST_W-1:0] const_ext;
  logic signed [SAMPLE_BITS+CONST_W-1:0] const_shift;
  logic signed [SAMPLE_BITS-1:0]    const_value;
  logic signed [SAMPLE_BITS-1:0]    square_value;
  logic signed [SAMPLE_BITS-1:0]    tri_value;
  logic signed [SAMPLE_BITS-1:0]    res;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_increment <= '0;
      waveform        <= WAVE_SINE;
      skew            <= SKEW_W'(32768);
      constant_value  <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PHASE_INCREMENT: phase_increment <= cfg_data[INC_W-1:0];
        REG_WAVEFORM:        waveform        <= wave_t'(cfg_data[1:0]);
        REG_SKEW:            skew            <= cfg_data[SKEW_W-1:0];
        REG_CONSTANT_VALUE:  constant_value  <= cfg_data[CONST_W-1:0];
        default: ;
      endcase
    end
  end

  assign tick.ready = (state == ST_IDLE);
  assign accept     = tick.valid && tick.ready;
  assign out_free   = !wave.valid || wave.ready;

  mwo_accum #(
    .PHASE_BITS (PHASE_BITS)
  ) u_accum (
    .clk   (clk),
    .rst   (rst),
    .start (acc_start),
    .clear (acc_clear),
    .inc   (phase_increment),
    .done  (acc_done),
    .frac  (frac)
  );

  mwo_sine #(
    .SAMPLE_BITS      (SAMPLE_BITS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_sine (
    .clk   (clk),
    .ctl   (sine_ctl),
    .frac  (frac),
    .value (sine_value)
  );

  mwo_div #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (quot)
  );

  // square and triangle share the skew compare
  assign skew_point   = {1'b0, skew, {(FRAC_W-SKEW_W){1'b0}}};
  assign rising       = {1'b0, frac} < skew_point;
  assign div_num      = rising ? {1'b0, frac} : ONE_CYCLE - {1'b0, frac};
  assign div_den      = rising ? skew_point : ONE_CYCLE - skew_point;
  assign square_value = rising ? FULL_NEG : FULL_POS;
  assign tri_value    = quot[SAMPLE_BITS] ? FULL_POS
                      : {~quot[SAMPLE_BITS-1], quot[SAMPLE_BITS-2:0]};

  // Q1.15 to Q1.(SAMPLE_BITS-1), floor when narrowing
  assign const_ext   = $signed({constant_value, {SAMPLE_BITS{1'b0}}});
  assign const_shift = const_ext >>> CONST_W;
  assign const_value = const_shift[SAMPLE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (waveform == WAVE_CONST) ? ST_FINISH : ST_ACCUM;
        end
      end
      ST_ACCUM: begin
        if (acc_done) begin
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        unique case (waveform)
          WAVE_SINE:     state_next = ST_SINE_RD;
          WAVE_TRIANGLE: state_next = ST_DIVIDE;
          default:       state_next = ST_FINISH;
        endcase
      end
      ST_SINE_RD:  state_next = ST_SINE_OUT;
      ST_SINE_OUT: state_next = ST_FINISH;
      ST_DIVIDE: begin
        if (div_done) begin
          state_next = ST_DIV_OUT;
        end
      end
      ST_DIV_OUT: state_next = ST_FINISH;
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    acc_start       = 1'b0;
    acc_clear       = 1'b0;
    sine_ctl.idx_en = 1'b0;
    sine_ctl.rd_en  = 1'b0;
    div_start       = 1'b0;
    out_load        = 1'b0;
    unique case (state)
      ST_IDLE: begin
        acc_clear = accept && tick.restart;
        acc_start = accept && (waveform != WAVE_CONST);
      end
      ST_EVAL: begin
        sine_ctl.idx_en = (waveform == WAVE_SINE);
        div_start       = (waveform == WAVE_TRIANGLE);
      end
      ST_SINE_RD: sine_ctl.rd_en = 1'b1;
      ST_FINISH:  out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          res <= const_value;
        end
      end
      ST_EVAL: begin
        if (waveform == WAVE_SQUARE) begin
          res <= square_value;
        end
      end
      ST_SINE_OUT: res <= sine_value;
      ST_DIV_OUT:  res <= tri_value;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      wave.valid <= 1'b0;
    end else if (out_load) begin
      wave.valid <= 1'b1;
    end else if (wave.ready) begin
      wave.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      wave.sample <= res;
    end
  end

`ifndef SYNTHESIS
  a_const_fast: assert property (@(posedge clk) disable iff (rst)
    accept && (waveform == WAVE_CONST) |=> state == ST_FINISH)
    else $error("constant item did not go straight to finish");

  a_acc_done_state: assert property (@(posedge clk) disable iff (rst)
    acc_done |-> state == ST_ACCUM)
    else $error("phase add finished outside accumulate state");

  a_finish_handoff: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH) && out_free |=> wave.valid && (state == ST_IDLE))
    else $error("result item not handed to output register");
`endif

endmodule

/* rtl/mwo_accum.sv */
// bit-serial phase accumulator, one sum bit per cycle
module mwo_accum #(
  parameter int PHASE_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      clear,
  input  logic [mwo_pkg::INC_W-1:0] inc,
  output logic                      done,
  output logic [mwo_pkg::FRAC_W-1:0] frac
);
  import mwo_pkg::*;

  localparam int CNT_W = $clog2(PHASE_BITS);

  logic [PHASE_BITS-1:0]        phase;
  logic [PHASE_BITS-1:0]        inc_sr;
  logic [PHASE_BITS-1:0]        inc_aligned;
  logic [PHASE_BITS+INC_W-1:0]  inc_wide;
  logic [PHASE_BITS+FRAC_W-1:0] phase_wide;
  logic [CNT_W-1:0]             cnt;
  logic                         busy;
  logic                         carry;
  logic                         carry_next;
  logic                         sum_bit;

  // align the Q0.32 increment and read back the Q0.32 fraction
  assign inc_wide    = {inc, {PHASE_BITS{1'b0}}};
  assign inc_aligned = inc_wide[PHASE_BITS+INC_W-1 -: PHASE_BITS];
  assign phase_wide  = {phase, {FRAC_W{1'b0}}};
  assign frac        = phase_wide[PHASE_BITS+FRAC_W-1 -: FRAC_W];

  assign sum_bit    = phase[0] ^ inc_sr[0] ^ carry;
  assign carry_next = (phase[0] & inc_sr[0]) | (carry & (phase[0] ^ inc_sr[0]));
  assign done       = busy && (cnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
      busy  <= 1'b0;
      cnt   <= '0;
    end else begin
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(PHASE_BITS - 1);
      end else if (busy) begin
        phase <= {sum_bit, phase[PHASE_BITS-1:1]};
        cnt   <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
        end
      end
      if (clear) begin
        phase <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      inc_sr <= inc_aligned;
      carry  <= 1'b0;
    end else if (busy) begin
      inc_sr <= {1'b0, inc_sr[PHASE_BITS-1:1]};
      carry  <= carry_next;
    end
  end

endmodule

/* rtl/mwo_sine.sv */
// sine index multiply, quadrant folding and quarter-wave table
module mwo_sine #(
  parameter int SAMPLE_BITS      = 16,
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic                           clk,
  input  mwo_pkg::sine_ctl_t             ctl,
  input  logic [mwo_pkg::FRAC_W-1:0]     frac,
  output logic signed [SAMPLE_BITS-1:0]  value
);
  import mwo_pkg::*;

  localparam int QUARTER = SINE_TABLE_DEPTH / 4;
  localparam int IDX_W   = $clog2(SINE_TABLE_DEPTH);
  localparam int ADDR_W  = $clog2(QUARTER + 1);
  localparam int PROD_W  = FRAC_W + IDX_W;
  localparam longint unsigned FULL_POS_L = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
  localparam logic [IDX_W:0] Q1 = (IDX_W+1)'(QUARTER);
  localparam logic [IDX_W:0] Q2 = (IDX_W+1)'(2 * QUARTER);
  localparam logic [IDX_W:0] Q3 = (IDX_W+1)'(3 * QUARTER);
  localparam logic [IDX_W:0] Q4 = (IDX_W+1)'(4 * QUARTER);

  // taylor-style nested polynomial in Q2.30, evaluated at elaboration
  function automatic logic [SAMPLE_BITS-2:0] quarter_sine(input int j);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    x  = (64'(j) * HALF_PI_Q30) / QUARTER;
    x2 = (x * x) >> 30;
    t  = Q30_ONE;
    t  = Q30_ONE - (((x2 * t) >> 30) / 156);
    t  = Q30_ONE - (((x2 * t) >> 30) / 110);
    t  = Q30_ONE - (((x2 * t) >> 30) / 72);
    t  = Q30_ONE - (((x2 * t) >> 30) / 42);
    t  = Q30_ONE - (((x2 * t) >> 30) / 20);
    t  = Q30_ONE - (((x2 * t) >> 30) / 6);
    s  = (x * t) >> 30;
    if (s > Q30_ONE) begin
      s = Q30_ONE;
    end
    return (SAMPLE_BITS-1)'((s * FULL_POS_L + (Q30_ONE >> 1)) >> 30);
  endfunction

  logic [SAMPLE_BITS-2:0] rom [QUARTER+1];
  logic [PROD_W-1:0]      prod;
  logic [IDX_W-1:0]       idx;
  logic [IDX_W:0]         idx_x;
  logic [IDX_W:0]         fold;
  logic [ADDR_W-1:0]      addr;
  logic                   neg;
  logic [SAMPLE_BITS-2:0] rom_q;
  logic                   neg_q;

  for (genvar gj = 0; gj <= QUARTER; gj++) begin : g_rom
    assign rom[gj] = quarter_sine(gj);
  end

  assign prod  = PROD_W'(frac) * PROD_W'(SINE_TABLE_DEPTH);
  assign idx_x = {1'b0, idx};

  always_comb begin
    if (idx_x < Q1) begin
      fold = idx_x;
    end else if (idx_x < Q2) begin
      fold = Q2 - idx_x;
    end else if (idx_x < Q3) begin
      fold = idx_x - Q2;
    end else begin
      fold = Q4 - idx_x;
    end
  end

  assign addr = fold[ADDR_W-1:0];
  assign neg  = idx_x >= Q2;

  always_ff @(posedge clk) begin
    if (ctl.idx_en) begin
      idx <= prod[PROD_W-1:FRAC_W];
    end
    if (ctl.rd_en) begin
      rom_q <= rom[addr];
      neg_q <= neg;
    end
  end

  assign value = neg_q ? -$signed({1'b0, rom_q}) : $signed({1'b0, rom_q});

endmodule

/* rtl/mwo_div.sv */
// restoring divider for the triangle ramp, one quotient bit per cycle
module mwo_div #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [mwo_pkg::FRAC_W:0]  num,
  input  logic [mwo_pkg::FRAC_W:0]  den,
  output logic                      done,
  output logic [SAMPLE_BITS:0]      quot
);
  import mwo_pkg::*;

  localparam int CNT_W = $clog2(SAMPLE_BITS + 1);

  logic [FRAC_W:0]   rem;
  logic [FRAC_W:0]   den_q;
  logic              next_bit;
  logic [FRAC_W+1:0] r2;
  logic [FRAC_W+1:0] diff;
  logic              ge;
  logic [CNT_W-1:0]  cnt;
  logic              busy;

  assign r2   = {rem, next_bit};
  assign diff = r2 - {1'b0, den_q};
  assign ge   = r2 >= {1'b0, den_q};
  assign done = busy && (cnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(SAMPLE_BITS);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == '0) begin
        busy <= 1'b0;
      end
    end
  end

  // dividend is num followed by SAMPLE_BITS zeros; num >> 1 is below den
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= {1'b0, num[FRAC_W:1]};
      next_bit <= num[0];
      den_q    <= den;
    end else if (busy) begin
      rem      <= ge ? diff[FRAC_W:0] : r2[FRAC_W:0];
      next_bit <= 1'b0;
      quot     <= {quot[SAMPLE_BITS-1:0], ge};
    end
  end

`ifndef SYNTHESIS
  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    busy |-> rem < den_q)
    else $error("partial remainder not below divisor");
`endif

endmodule

/* tb/oscillator_sample_check.sv */
// watches the oscillator channels, predicts each sample and compares it with the block's output
module oscillator_sample_check (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [mwo_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mwo_pkg::CFG_DATA_W-1:0]  cfg_data,
  mwo_in_if                               tick,
  mwo_out_if                              wave,
  output int unsigned                     mismatches,
  output int unsigned                     pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import mwo_pkg::*;

  localparam int              FULL_POS = 32767;
  localparam int              FULL_NEG = -32768;
  localparam longint unsigned QUARTER  = 64'd256;
  localparam longint unsigned TWO32    = 64'h1_0000_0000;

  logic [INC_W-1:0]          inc_reg;
  wave_t                     wave_sel;
  logic [SKEW_W-1:0]         skew_reg;
  logic signed [CONST_W-1:0] const_reg;
  logic [FRAC_W-1:0]         osc_phase;

  int                        sine_quarter [0:256];
  logic signed [15:0]        expected_samples [$];
  int unsigned               result_count;

  function automatic int quarter_amp(input int unsigned j);
    longint unsigned x, x2, t, s;
    x  = (64'(j) * HALF_PI_Q30) / QUARTER;
    x2 = (x * x) >> 30;
    t  = Q30_ONE;
    t  = Q30_ONE - (((x2 * t) >> 30) / 64'd156);
    t  = Q30_ONE - (((x2 * t) >> 30) / 64'd110);
    t  = Q30_ONE - (((x2 * t) >> 30) / 64'd72);
    t  = Q30_ONE - (((x2 * t) >> 30) / 64'd42);
    t  = Q30_ONE - (((x2 * t) >> 30) / 64'd20);
    t  = Q30_ONE - (((x2 * t) >> 30) / 64'd6);
    s  = (x * t) >> 30;
    if (s > Q30_ONE) s = Q30_ONE;
    return int'((s * 64'(FULL_POS) + (Q30_ONE >> 1)) >> 30);
  endfunction

  function automatic logic signed [15:0] next_sample(input logic restart);
    logic [FRAC_W-1:0] f;
    logic [9:0]        idx;
    longint unsigned   num, den;
    int                v;
    if (restart) osc_phase = '0;
    if (wave_sel == WAVE_CONST) return const_reg;
    osc_phase = osc_phase + inc_reg;
    f = osc_phase;
    v = 0;
    case (wave_sel)
      WAVE_SINE: begin
        idx = f[31:22];
        case (idx[9:8])
          2'd0:    v = sine_quarter[idx[7:0]];
          2'd1:    v = sine_quarter[256 - idx[7:0]];
          2'd2:    v = -sine_quarter[idx[7:0]];
          default: v = -sine_quarter[256 - idx[7:0]];
        endcase
      end
      WAVE_SQUARE: begin
        v = (f < {skew_reg, 16'h0000}) ? FULL_NEG : FULL_POS;
      end
      WAVE_TRIANGLE: begin
        if (f < {skew_reg, 16'h0000}) begin
          num = 64'(f) << 16;
          den = 64'(skew_reg) << 16;
        end else begin
          num = (TWO32 - 64'(f)) << 16;
          den = TWO32 - (64'(skew_reg) << 16);
        end
        v = int'(num / den) + FULL_NEG;
        if (v > FULL_POS) v = FULL_POS;
      end
      default: v = 0;
    endcase
    return v[15:0];
  endfunction

  initial begin
    for (int j = 0; j <= 256; j++) sine_quarter[j] = quarter_amp(j);
  end

  always @(posedge clk) begin
    logic signed [15:0] want;
    if (rst) begin
      inc_reg      = '0;
      wave_sel     = WAVE_SINE;
      skew_reg     = 16'h8000;
      const_reg    = '0;
      osc_phase    = '0;
      mismatches   = 0;
      result_count = 0;
      expected_samples.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_PHASE_INCREMENT: inc_reg   = cfg_data[INC_W-1:0];
          REG_WAVEFORM:        wave_sel  = wave_t'(cfg_data[1:0]);
          REG_SKEW:            skew_reg  = cfg_data[SKEW_W-1:0];
          REG_CONSTANT_VALUE:  const_reg = cfg_data[CONST_W-1:0];
          default: ;
        endcase
      end
      if (wave.valid && wave.ready) begin
        result_count++;
        if (expected_samples.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("sample %0d: got %0d with no item outstanding", result_count, wave.sample);
        end else begin
          want = expected_samples.pop_front();
          if (wave.sample !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("sample %0d: expected %0d, got %0d", result_count, want, wave.sample);
          end
        end
      end
      if (tick.valid && tick.ready) expected_samples.push_back(next_sample(tick.restart));
    end
    pending = expected_samples.size();
  end

endmodule

/* tb/multi_waveform_oscillator_core_tb.sv */
// stimulus and verdict for the multi-waveform oscillator core
module multi_waveform_oscillator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mwo_pkg::*;

  localparam int unsigned               CYCLE_LIMIT      = 1000000;
  localparam logic [CFG_INDEX_W-1:0]    REG_UNUSED_FIRST = 3'd4;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int unsigned            mismatches;
  int unsigned            pending;
  int unsigned            cycles = 0;
  int                     src_idle_pct = 0;
  int                     snk_idle_pct = 0;
  bit                     long_hold = 1'b0;

  mwo_in_if                       tick_ch ();
  mwo_out_if #(.SAMPLE_BITS(16))  wave_ch ();

  multi_waveform_oscillator_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tick      (tick_ch),
    .wave      (wave_ch)
  );

  oscillator_sample_check i_sample_check (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .tick       (tick_ch),
    .wave       (wave_ch),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("multi_waveform_oscillator_core test failed");
      $finish;
    end
  end

  // sample receiver with random stalls and one long hold-off
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    wave_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold && !hold_done) begin
        hold_left = 400;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        wave_ch.ready <= 1'b0;
      end else begin
        wave_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  task automatic offer_tick(input logic restart);
    while ($urandom_range(99) < src_idle_pct) begin
      tick_ch.valid <= 1'b0;
      @(negedge clk);
    end
    tick_ch.valid   <= 1'b1;
    tick_ch.restart <= restart;
    @(posedge clk);
    while (!tick_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_samples();
    tick_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  task automatic load_osc(input logic [31:0] inc, input wave_t wsel,
                          input logic [15:0] skew, input logic [15:0] cval);
    drain_samples();
    write_reg(REG_PHASE_INCREMENT, inc);
    write_reg(REG_WAVEFORM, {30'd0, wsel});
    write_reg(REG_SKEW, {16'd0, skew});
    write_reg(REG_CONSTANT_VALUE, {16'd0, cval});
  endtask

  task automatic random_setting(output int restart_pct);
    logic [31:0] inc;
    logic [31:0] skew_word;
    case ($urandom_range(7))
      0:       inc = 32'hFFFF_FFFF;
      1:       inc = $urandom_range(255);
      2:       inc = '0;
      3:       inc = 32'h8000_0000 + $urandom_range(15);
      default: inc = $urandom();
    endcase
    skew_word = $urandom();
    case ($urandom_range(5))
      0:       skew_word[15:0] = 16'h0000;
      1:       skew_word[15:0] = 16'hFFFF;
      2:       skew_word[15:0] = 16'h0001;
      default: ;
    endcase
    case ($urandom_range(2))
      0:       restart_pct = 3;
      1:       restart_pct = 20;
      default: restart_pct = 50;
    endcase
    drain_samples();
    write_reg(REG_PHASE_INCREMENT, inc);
    write_reg(REG_WAVEFORM, $urandom());
    write_reg(REG_SKEW, skew_word);
    write_reg(REG_CONSTANT_VALUE, $urandom());
    if ($urandom_range(3) == 0)
      write_reg(REG_UNUSED_FIRST + 3'($urandom_range(3)), $urandom());
  endtask

  initial begin
    int restart_pct;
    tick_ch.valid   = 1'b0;
    tick_ch.restart = 1'b0;
    cfg_write       = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset values: sine at zero increment
    offer_tick(1'b0);
    offer_tick(1'b1);

    // sine at quadrant boundaries, then off-grid phases
    load_osc(32'h4000_0000, WAVE_SINE, 16'h8000, 16'h0000);
    repeat (4) offer_tick(1'b0);
    load_osc(32'h0123_4567, WAVE_SINE, 16'h8000, 16'h0000);
    offer_tick(1'b1);
    offer_tick(1'b0);

    // square with zero skew, then full skew with wrapping phase
    load_osc(32'h1000_0000, WAVE_SQUARE, 16'h0000, 16'h0000);
    offer_tick(1'b1);
    offer_tick(1'b0);
    load_osc(32'hFFFF_FFFF, WAVE_SQUARE, 16'hFFFF, 16'h0000);
    offer_tick(1'b1);
    offer_tick(1'b0);

    // triangle falling only, full skew, centered
    load_osc(32'h8000_0000, WAVE_TRIANGLE, 16'h0000, 16'h0000);
    offer_tick(1'b1);
    offer_tick(1'b0);
    load_osc(32'h4000_0000, WAVE_TRIANGLE, 16'hFFFF, 16'h0000);
    offer_tick(1'b1);
    offer_tick(1'b0);
    load_osc(32'h1000_0000, WAVE_TRIANGLE, 16'h8000, 16'h0000);
    repeat (3) offer_tick(1'b0);

    // constant extremes, restart clears a held phase
    load_osc(32'h4000_0000, WAVE_CONST, 16'h8000, 16'h8000);
    offer_tick(1'b0);
    load_osc(32'h4000_0000, WAVE_CONST, 16'h8000, 16'h7FFF);
    offer_tick(1'b1);
    load_osc(32'h4000_0000, WAVE_SINE, 16'h8000, 16'h7FFF);
    offer_tick(1'b0);

    // unused indexes and bits above the register width
    drain_samples();
    for (int k = 0; k < 4; k++) write_reg(REG_UNUSED_FIRST + 3'(k), $urandom());
    write_reg(REG_WAVEFORM, 32'hFFFF_FFFE);
    offer_tick(1'b0);

    for (int p = 0; p < 4; p++) begin
      case (p)
        0:       begin src_idle_pct = 0;  snk_idle_pct = 0;  end
        1:       begin src_idle_pct = 55; snk_idle_pct = 0;  end
        2:       begin src_idle_pct = 0;  snk_idle_pct = 55; end
        default: begin src_idle_pct = 34; snk_idle_pct = 34; end
      endcase
      for (int s = 0; s < 6; s++) begin
        random_setting(restart_pct);
        if (p == 0 && s == 1) long_hold = 1'b1;
        repeat (68) offer_tick($urandom_range(99) < restart_pct);
      end
    end

    drain_samples();
    repeat (100) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("multi_waveform_oscillator_core test passed");
    end else begin
      $display("multi_waveform_oscillator_core test failed");
    end
    $finish;
  end

endmodule
